FILE: hw/rtl/opta_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes and fixed-point helpers for the 4x4 outer-product
// tile accumulator. No dependencies.
package opta_pkg;

    localparam int TILE = 4;
    localparam int COL_W = $clog2(TILE);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ACCUM = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic signed [31:0] ALPHA_RESET = 32'sd65536;

    typedef logic signed [31:0] elem_t;
    typedef logic signed [63:0] acc_t;
    typedef acc_t  [TILE-1:0] acc_row_t;
    typedef acc_row_t [TILE-1:0] tile_t;
    typedef elem_t [TILE-1:0] elem_vec_t;

    typedef struct packed {
        logic [1:0] cmd;
        elem_t      a0;
        elem_t      a1;
        elem_t      a2;
        elem_t      a3;
        elem_t      b0;
        elem_t      b1;
        elem_t      b2;
        elem_t      b3;
        logic [1:0] row_select;
    } req_t;

    typedef struct packed {
        logic [1:0] row_index;
        acc_t       c0;
        acc_t       c1;
        acc_t       c2;
        acc_t       c3;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SAT,
        ST_MUL,
        ST_DRAIN
    } state_t;

    // Per-cycle control broadcast from the sequencer to every row lane
    typedef struct packed {
        logic             clear;
        logic             load;
        logic             scale;
        logic             sat;
        logic             mul;
        logic             add;
        logic [COL_W-1:0] add_col;
    } lane_ctrl_t;

    // Q32.32 product to Q16.16: floor shift by 16, then clamp to 32 bits
    function automatic elem_t sat_q16(input acc_t p);
        logic signed [47:0] q;
        elem_t              r;
        q = p[63:16];
        if ((&q[47:31]) || !(|q[47:31]))
            r = q[31:0];
        else if (q[47])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    function automatic acc_t sat_add64(input acc_t x, input acc_t y);
        acc_t s;
        acc_t r;
        s = x + y;
        if ((x[63] == y[63]) && (s[63] != x[63]))
            r = x[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        else
            r = s;
        return r;
    endfunction

endpackage

FILE: hw/rtl/opta_lane.sv
`timescale 1ns / 1ps
// One tile row: operand registers, a shared 32x32 multiplier, the scaled-b
// register and four saturating Q32.32 accumulators. Uses opta_pkg.
module opta_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  opta_pkg::lane_ctrl_t ctrl,
    input  opta_pkg::elem_t     alpha,
    input  opta_pkg::elem_t     a_in,
    input  opta_pkg::elem_t     b_in,
    input  opta_pkg::elem_t     bs_sel,
    output opta_pkg::elem_t     bs,
    output opta_pkg::acc_row_t  acc_row
);
    import opta_pkg::*;

    elem_t    a_reg;
    elem_t    b_reg;
    elem_t    bs_reg;
    acc_t     prod_reg;
    acc_t     prod_next;
    elem_t    mul_a;
    elem_t    mul_b;
    acc_row_t acc_reg;

    // Scale phase: alpha * own b; column phase: own a * selected scaled b
    assign mul_a     = ctrl.scale ? alpha : a_reg;
    assign mul_b     = ctrl.scale ? b_reg : bs_sel;
    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
        end
        if (ctrl.scale || ctrl.mul)
            prod_reg <= prod_next;
        if (ctrl.sat)
            bs_reg <= sat_q16(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (ctrl.clear)
            acc_reg <= '0;
        else if (ctrl.add)
            acc_reg[ctrl.add_col] <= sat_add64(acc_reg[ctrl.add_col], prod_reg);
    end

    assign bs      = bs_reg;
    assign acc_row = acc_reg;

endmodule

FILE: hw/rtl/opta_merge.sv
`timescale 1ns / 1ps
// Output stage: picks one row out of the lanes on a read transaction and holds
// it in the response register until taken. Uses opta_pkg.
module opta_merge (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic [1:0]      row_select,
    input  opta_pkg::tile_t rows,
    input  logic            rsp_ready,
    output logic            rsp_valid,
    output opta_pkg::rsp_t  rsp
);
    import opta_pkg::*;

    logic     rsp_valid_reg;
    rsp_t     rsp_reg;
    acc_row_t sel_row;

    assign sel_row = rows[row_select];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (load)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg.row_index <= row_select;
            rsp_reg.c0        <= sel_row[0];
            rsp_reg.c1        <= sel_row[1];
            rsp_reg.c2        <= sel_row[2];
            rsp_reg.c3        <= sel_row[3];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: hw/rtl/outer_product_tile_accumulator_core.sv
`timescale 1ns / 1ps
// Usage
//   Request channel (req_valid/req_ready/req): clear, accumulate or read
//   commands. Command code 3 is accepted and dropped.
//   Response channel (rsp_valid/rsp_ready/rsp): one transaction per read,
//   carrying the selected tile row. cfg_we/cfg_wdata write alpha (Q16.16)
//   whenever the block is idle; no wait.
// Sequencing
//   Clear and read are handled on acceptance; read data is valid the cycle after
//   acceptance. An accumulate holds off the next request until it is done:
//   one scale multiply, one saturate step, then four column multiplies on
//   each row lane's single multiplier, with the last accumulate add
//   draining in the drain state.
// Reset
//   The whole tile is zero and alpha is 1.0 after reset; no clearing pass.
// Backpressure
//   A stalled response holds in the output register. Clear and accumulate
//   requests are still taken; a read waits until the pending response leaves.
// Depends on opta_pkg, opta_lane and opta_merge.
module outer_product_tile_accumulator_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  opta_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output opta_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata
);
    import opta_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             add_pend_reg;
    logic [COL_W-1:0] add_col_reg;
    elem_t            alpha_reg;
    logic             req_fire;
    lane_ctrl_t       ctrl;
    elem_vec_t        a_vec;
    elem_vec_t        b_vec;
    elem_vec_t        bs_vec;
    elem_t            bs_sel;
    tile_t            tile;

    assign a_vec[0] = req.a0;
    assign a_vec[1] = req.a1;
    assign a_vec[2] = req.a2;
    assign a_vec[3] = req.a3;
    assign b_vec[0] = req.b0;
    assign b_vec[1] = req.b1;
    assign b_vec[2] = req.b2;
    assign b_vec[3] = req.b3;

    assign req_ready = (state_reg == ST_IDLE)
                       && ((req.cmd != CMD_READ) || !rsp_valid || rsp_ready);
    assign req_fire  = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_reg <= ALPHA_RESET;
        else if (cfg_we)
            alpha_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            add_pend_reg <= 1'b0;
            add_col_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            add_pend_reg <= (state_reg == ST_MUL);
            add_col_reg  <= col_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.cmd == CMD_ACCUM))
                    state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_SAT;
            ST_SAT:   state_next = ST_MUL;
            ST_MUL:
            begin
                if (col_reg == COL_W'(TILE - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl         = '0;
        col_next     = '0;
        ctrl.clear   = req_fire && (req.cmd == CMD_CLEAR);
        ctrl.load    = req_fire && (req.cmd == CMD_ACCUM);
        ctrl.add     = add_pend_reg;
        ctrl.add_col = add_col_reg;
        unique case (state_reg) inside
            ST_SCALE: ctrl.scale = 1'b1;
            ST_SAT:   ctrl.sat = 1'b1;
            ST_MUL:
            begin
                ctrl.mul = 1'b1;
                col_next = col_reg + 1'b1;
            end
            ST_IDLE, ST_DRAIN: ;
            default: ;
        endcase
    end

    assign bs_sel = bs_vec[col_reg];

    for (genvar g = 0; g < TILE; g++)
    begin : g_lane
        opta_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .alpha   (alpha_reg),
            .a_in    (a_vec[g]),
            .b_in    (b_vec[g]),
            .bs_sel  (bs_sel),
            .bs      (bs_vec[g]),
            .acc_row (tile[g])
        );
    end

    opta_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (req_fire && (req.cmd == CMD_READ)),
        .row_select (req.row_select),
        .rows       (tile),
        .rsp_ready  (rsp_ready),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp)
    );

endmodule

FILE: hw/rtl/opta_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the tile accumulator, bound to the top level.
// Depends on opta_pkg and outer_product_tile_accumulator_core.
module opta_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input opta_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input opta_pkg::rsp_t rsp
);
    import opta_pkg::*;

    // Stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Read returns the requested row on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.cmd == CMD_READ)
        |=> rsp_valid && (rsp.row_index == $past(req.row_select)))
        else $error("read response missing or wrong row");

    // A new response only follows a read transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready && (req.cmd == CMD_READ)))
        else $error("response without read");

    // Accumulate occupies the lanes
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.cmd == CMD_ACCUM) |=> !req_ready)
        else $error("request taken during accumulate");

    // Read right after clear returns zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.cmd == CMD_CLEAR))
        ##1 (req_valid && req_ready && (req.cmd == CMD_READ))
        |=> (rsp.c0 == 0) && (rsp.c1 == 0) && (rsp.c2 == 0) && (rsp.c3 == 0))
        else $error("tile not cleared");

endmodule

bind outer_product_tile_accumulator_core opta_checker u_opta_checker (.*);
